// ----- rtl/core/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants for the unique value stack
// Holds the stack depth, field widths, status codes and the control struct
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

    // Number of cells in the chain
    localparam int DEPTH = 64;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // Command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Reset value of the capacity register
    localparam logic [COUNT_W-1:0] CAPACITY_RST = 7'd64;

    // Chain control, common to all cells
    typedef struct packed {
        logic probe;  // compare held entry with the incoming key
        logic push;   // shift towards the bottom, new key enters at the top
        logic pop;    // shift towards the top, bottom cell empties
    } uvs_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/uvs_cell.sv -----
// ----------------------------------------------------------------------------
// uvs_cell: one slot of the stack chain
// Holds one entry and its valid flag, shifts with its neighbours on push and
// pop, and registers whether its entry equals the probed key.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire uvs_pkg::uvs_ctl_t             ctl,
    input  wire logic [uvs_pkg::VALUE_W-1:0]   probe_key,
    input  wire logic [uvs_pkg::VALUE_W-1:0]   above_data,
    input  wire logic                          above_valid,
    input  wire logic [uvs_pkg::VALUE_W-1:0]   below_data,
    input  wire logic                          below_valid,
    output logic      [uvs_pkg::VALUE_W-1:0]   data,
    output logic                               valid,
    output logic                               hit
);

    logic [uvs_pkg::VALUE_W-1:0] data_reg;
    logic                        valid_reg;
    logic                        hit_reg;

    // Valid flag and match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctl.push) begin
                valid_reg <= above_valid;
            end else if (ctl.pop) begin
                valid_reg <= below_valid;
            end
            if (ctl.probe) begin
                hit_reg <= valid_reg && (data_reg == probe_key);
            end
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            data_reg <= above_data;
        end else if (ctl.pop) begin
            data_reg <= below_data;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// ----- rtl/core/unique_value_stack.sv -----
// ----------------------------------------------------------------------------
// unique_value_stack: LIFO stack of signed 32-bit values without duplicates
// A chain of cells with the top entry in the first cell; every cell compares
// its entry with the pushed value in parallel to find duplicates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tdata carries the value, s_tuser the command
//   (0 push, 1 pop). Result channel m_*: one transfer per input transfer,
//   carrying the popped value, a status and the occupancy afterwards.
//   For each item, the per-cell match flags are registered as the input is
//   taken; the S_DECIDE state then decides, shifts the cell chain and
//   registers the result, which raises m_tvalid. No new item is taken in
//   S_DECIDE; the next item can be taken at the edge of the result
//   transfer. A stalled receiver holds the result and s_tready stays low.
//   cfg_wr_en / cfg_wr_data write the capacity (reset 64, limited to the
//   chain depth of 64); write it only while the block is idle.
//   Reset (aresetn low, synchronous) empties the stack; entry data is not
//   cleared, only the valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_value_stack (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // capacity register
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] value
    input  wire logic        s_tuser,    // [0] cmd
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata     // [31:0] popped_value, [33:32] status,
                                         // [40:34] occupancy, [47:41] zero
);

    localparam int VW = uvs_pkg::VALUE_W;
    localparam int CW = uvs_pkg::COUNT_W;
    localparam int N  = uvs_pkg::DEPTH;

    localparam logic [CW-1:0] DEPTH_C = CW'(N);

    // Sequencer states
    localparam logic S_IDLE   = 1'b0;
    localparam logic S_DECIDE = 1'b1;

    logic                        state_reg, state_next;
    logic [CW-1:0]               capacity_reg;
    logic [CW-1:0]               count_reg, count_next;
    logic                        cmd_reg;
    logic [VW-1:0]               key_reg;
    logic                        m_valid_reg, m_valid_next;
    logic [VW-1:0]               m_popped_reg, m_popped_next;
    logic [uvs_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CW-1:0]               m_occ_reg;

    logic                        accept;
    logic [CW-1:0]               limit;
    logic                        any_hit;
    uvs_pkg::uvs_ctl_t           ctl;

    logic [VW-1:0]               cell_data  [N];
    logic [N-1:0]                cell_valid;
    logic [N-1:0]                cell_hit;

    // Take an item only while idle and when the result register will be free
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign limit   = (capacity_reg > DEPTH_C) ? DEPTH_C : capacity_reg;
    assign any_hit = |cell_hit;

    // Decide the operation and the result
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_popped_next = m_popped_reg;
        m_status_next = m_status_reg;
        ctl.probe     = accept;
        ctl.push      = 1'b0;
        ctl.pop       = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next    = S_IDLE;
                m_valid_next  = 1'b1;
                m_popped_next = '0;
                if (cmd_reg == uvs_pkg::CMD_PUSH) begin
                    if (count_reg >= limit) begin
                        m_status_next = uvs_pkg::ST_FULL;
                    end else if (any_hit) begin
                        m_status_next = uvs_pkg::ST_DUP;
                    end else begin
                        m_status_next = uvs_pkg::ST_OK;
                        ctl.push      = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end else begin
                    if (count_reg == '0) begin
                        m_status_next = uvs_pkg::ST_EMPTY;
                    end else begin
                        m_status_next = uvs_pkg::ST_OK;
                        m_popped_next = cell_data[0];
                        ctl.pop       = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            capacity_reg <= uvs_pkg::CAPACITY_RST;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata;
        end
        m_popped_reg <= m_popped_next;
        m_status_reg <= m_status_next;
        if (state_reg == S_DECIDE) begin
            m_occ_reg <= count_next;
        end
    end

    // Chain of cells, top of stack in cell 0
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [VW-1:0] above_d, below_d;
        logic          above_v, below_v;
        if (i == 0) begin : g_top
            assign above_d = key_reg;
            assign above_v = 1'b1;
        end else begin : g_mid
            assign above_d = cell_data[i-1];
            assign above_v = cell_valid[i-1];
        end
        if (i == N - 1) begin : g_bot
            assign below_d = '0;
            assign below_v = 1'b0;
        end else begin : g_up
            assign below_d = cell_data[i+1];
            assign below_v = cell_valid[i+1];
        end
        uvs_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .probe_key   (s_tdata),
            .above_data  (above_d),
            .above_valid (above_v),
            .below_data  (below_d),
            .below_valid (below_v),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .hit         (cell_hit[i])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_occ_reg, m_status_reg, m_popped_reg};

    // Checks
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("occupancy beyond chain depth");

    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid flags disagree with occupancy");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ##1 m_tvalid)
        else $error("no result two cycles after input transfer");

    a_no_take_in_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DECIDE) |-> !s_tready)
        else $error("input taken while deciding");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the unique value stack
// Drives push and pop transfers with random gaps on both channels, keeps its
// own model of the stack contents and capacity, and compares every result
// transfer field by field. A short directed sequence covers the extremes and
// every status code; random phases at several capacities follow.
// ----------------------------------------------------------------------------
module testbench;

    import uvs_pkg::*;

    // One result transfer, laid out as in m_tdata from bit 40 down to bit 0
    typedef struct packed {
        logic [COUNT_W-1:0]  occupancy;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  popped;
    } op_result_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,   // expected result comes from the stack model
        ROW_TYPED,     // expected result given in the row
        ROW_CAPACITY   // write the capacity register
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                cmd;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  cap;
        op_result_t          result;
    } stim_row_t;

    localparam op_result_t NO_RESULT = '0;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         PHASE_ITEMS = 225;
    localparam int         NUM_PHASES  = 8;

    // Directed sequence: extremes, duplicates, full, full with duplicate,
    // capacity lowered below occupancy, capacity zero, capacity above depth
    localparam stim_row_t DIRECTED_ROWS [27] = '{
        '{ROW_TYPED,    CMD_POP,  32'hA5A5_A5A5, 7'd0,   '{7'd0, ST_EMPTY, 32'h0}},
        '{ROW_TYPED,    CMD_PUSH, 32'h7FFF_FFFF, 7'd0,   '{7'd1, ST_OK, 32'h0}},
        '{ROW_TYPED,    CMD_PUSH, 32'h8000_0000, 7'd0,   '{7'd2, ST_OK, 32'h0}},
        '{ROW_PREDICT,  CMD_PUSH, 32'h0000_0000, 7'd0,   NO_RESULT},
        '{ROW_TYPED,    CMD_PUSH, 32'h8000_0000, 7'd0,   '{7'd3, ST_DUP, 32'h0}},
        '{ROW_PREDICT,  CMD_PUSH, 32'hFFFF_FFFF, 7'd0,   NO_RESULT},
        '{ROW_TYPED,    CMD_POP,  32'h5A5A_5A5A, 7'd0,   '{7'd3, ST_OK, 32'hFFFF_FFFF}},
        '{ROW_PREDICT,  CMD_POP,  32'hFFFF_FFFF, 7'd0,   NO_RESULT},
        '{ROW_TYPED,    CMD_POP,  32'h0000_0000, 7'd0,   '{7'd1, ST_OK, 32'h8000_0000}},
        '{ROW_CAPACITY, CMD_PUSH, 32'h0,         7'd2,   NO_RESULT},
        '{ROW_PREDICT,  CMD_PUSH, 32'h0000_0001, 7'd0,   NO_RESULT},
        '{ROW_TYPED,    CMD_PUSH, 32'h0000_0001, 7'd0,   '{7'd2, ST_FULL, 32'h0}},
        '{ROW_PREDICT,  CMD_PUSH, 32'h0000_0002, 7'd0,   NO_RESULT},
        '{ROW_CAPACITY, CMD_PUSH, 32'h0,         7'd1,   NO_RESULT},
        '{ROW_PREDICT,  CMD_PUSH, 32'h0000_0003, 7'd0,   NO_RESULT},
        '{ROW_PREDICT,  CMD_POP,  32'h1234_5678, 7'd0,   NO_RESULT},
        '{ROW_PREDICT,  CMD_PUSH, 32'h0000_0005, 7'd0,   NO_RESULT},
        '{ROW_TYPED,    CMD_POP,  32'h0000_0000, 7'd0,   '{7'd0, ST_OK, 32'h7FFF_FFFF}},
        '{ROW_TYPED,    CMD_POP,  32'hFFFF_FFFF, 7'd0,   '{7'd0, ST_EMPTY, 32'h0}},
        '{ROW_CAPACITY, CMD_PUSH, 32'h0,         7'd0,   NO_RESULT},
        '{ROW_TYPED,    CMD_PUSH, 32'h0000_0009, 7'd0,   '{7'd0, ST_FULL, 32'h0}},
        '{ROW_PREDICT,  CMD_POP,  32'h0000_0009, 7'd0,   NO_RESULT},
        '{ROW_CAPACITY, CMD_PUSH, 32'h0,         7'd127, NO_RESULT},
        '{ROW_PREDICT,  CMD_PUSH, 32'h5555_5555, 7'd0,   NO_RESULT},
        '{ROW_PREDICT,  CMD_PUSH, 32'hAAAA_AAAA, 7'd0,   NO_RESULT},
        '{ROW_PREDICT,  CMD_POP,  32'h0000_0000, 7'd0,   NO_RESULT},
        '{ROW_PREDICT,  CMD_POP,  32'hFFFF_FFFF, 7'd0,   NO_RESULT}
    };

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [47:0]         m_tdata;

    // Stack model state
    logic [VALUE_W-1:0]  held_values [DEPTH];
    int                  held_count = 0;
    logic [COUNT_W-1:0]  capacity   = CAPACITY_RST;

    op_result_t          due_results [$];
    int                  mismatches   = 0;
    int                  quiet_cycles = 0;
    bit                  tx_steady    = 1'b0;
    bit                  rx_steady    = 1'b0;
    int                  push_outcomes [4] = '{0, 0, 0, 0};
    int                  pop_outcomes  [4] = '{0, 0, 0, 0};
    int                  peak_occupancy = 0;

    unique_value_stack DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [31:0] value
        .s_tuser     (s_tuser),     // [0] cmd
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)      // [31:0] popped_value, [33:32] status,
                                    // [40:34] occupancy, [47:41] zero
    );

    // Clock, period 20
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one operation to the stack model and return its result
    function automatic op_result_t stack_op_outcome(input logic cmd,
                                                    input logic [VALUE_W-1:0] val);
        op_result_t r;
        int         lim;
        bit         found;
        r     = NO_RESULT;
        lim   = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
        found = 1'b0;
        if (cmd == CMD_PUSH) begin
            for (int i = 0; i < held_count; i++) begin
                if (held_values[i] == val) found = 1'b1;
            end
            // a full stack rejects before the duplicate search counts
            if (held_count >= lim) begin
                r.status = ST_FULL;
            end else if (found) begin
                r.status = ST_DUP;
            end else begin
                held_values[held_count] = val;
                held_count++;
                r.status = ST_OK;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            held_count--;
            r.popped = held_values[held_count];
            r.status = ST_OK;
        end
        r.occupancy = COUNT_W'(held_count);
        return r;
    endfunction

    // Offer one operation, wait for its transfer and record what it owes
    task automatic send_op(input logic cmd, input logic [VALUE_W-1:0] val,
                           input bit use_given, input op_result_t given);
        int         gap;
        op_result_t predicted;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        predicted = stack_op_outcome(cmd, val);
        due_results.push_back(use_given ? given : predicted);
        if (cmd == CMD_PUSH) push_outcomes[predicted.status]++;
        else                 pop_outcomes[predicted.status]++;
        if (held_count > peak_occupancy) peak_occupancy = held_count;
    endtask

    // Drain, then write the capacity register while the block is idle
    task automatic set_capacity(input logic [COUNT_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        capacity     = cap;
    endtask

    // Receiver: hold m_tready low for a random stall before each result, or not at all in steady stretches
    initial begin : result_sink
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge aclk) begin : result_check
        op_result_t got;
        op_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[40:0];
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result transfer %h", $time, m_tdata);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (got.popped !== want.popped) begin
                    $display("%0t: popped_value expected %h got %h",
                             $time, want.popped, got.popped);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, got.status);
                    mismatches++;
                end
                if (got.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $time, want.occupancy, got.occupancy);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [COUNT_W-1:0] phase_caps [NUM_PHASES];
        logic [VALUE_W-1:0] extremes [4];
        logic [VALUE_W-1:0] val;
        logic               cmd;
        int                 seg_left;
        int                 push_pct;
        phase_caps = '{7'd64, 7'd3, 7'd127, 7'd1, 7'd0, 7'd64, 7'd2, 7'd0};
        extremes   = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        // random capacities: one below the chain depth, one above it
        phase_caps[4] = COUNT_W'($urandom_range(4, 63));
        phase_caps[7] = COUNT_W'($urandom_range(65, 127));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed rows
        foreach (DIRECTED_ROWS[i]) begin
            if (DIRECTED_ROWS[i].kind == ROW_CAPACITY) begin
                set_capacity(DIRECTED_ROWS[i].cap);
            end else begin
                send_op(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].value,
                        DIRECTED_ROWS[i].kind == ROW_TYPED, DIRECTED_ROWS[i].result);
            end
        end

        // random phases: push-heavy and pop-heavy stretches at each capacity
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_capacity(phase_caps[p]);
            seg_left = 0;
            push_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (seg_left == 0) begin
                    seg_left  = $urandom_range(8, 80);
                    push_pct  = (push_pct >= 50) ? 25 : 80;
                    tx_steady = ($urandom_range(0, 3) == 0);
                end
                seg_left--;
                cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                // small values collide often; extremes and full words cover the bits
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: val = VALUE_W'(int'($urandom_range(0, 15)) - 8);
                    4, 5:       val = extremes[$urandom_range(0, 3)];
                    default:    val = $urandom;
                endcase
                send_op(cmd, val, 1'b0, NO_RESULT);
            end
        end

        // drain and let the pipeline settle
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("pushes: %0d stored, %0d duplicates, %0d full; peak occupancy %0d",
                 push_outcomes[ST_OK], push_outcomes[ST_DUP], push_outcomes[ST_FULL],
                 peak_occupancy);
        $display("pops: %0d returned a value, %0d on an empty stack; %0d mismatches",
                 pop_outcomes[ST_OK], pop_outcomes[ST_EMPTY], mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
